// ===== design/mrsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsb_pkg
// Shared constants, codes and types of the single-base Miller-Rabin core.
// ----------------------------------------------------------------------------
package mrsb_pkg;

    // datapath width; fields are truncated to it
    localparam int WIDTH      = 32;
    localparam int FIELD_W    = 32;
    localparam int S_TDATA_W  = 2 * FIELD_W;
    localparam int VERDICT_W  = 2;
    localparam int M_TDATA_W  = 8;
    // holds a count of trailing zeros of n-1, at most WIDTH-1
    localparam int K_W        = $clog2(WIDTH);

    localparam logic [VERDICT_W-1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INVALID   = 2'd2;

    localparam logic [WIDTH-1:0] SMALL_PRIME     = WIDTH'(3);
    localparam logic [WIDTH-1:0] SMALL_COMPOSITE = WIDTH'(4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SPLIT,
        ST_POW,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_TEST,
        ST_LOOP,
        ST_LOOP_SQR,
        ST_DONE
    } mrsb_state_t;

    // request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] op_a;
        logic [WIDTH-1:0] op_b;
    } mm_req_t;

    // status from the modular multiplier
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] product;
    } mm_rsp_t;

endpackage

// ===== design/mrsb_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrsb_mulmod
// Bit-serial modular multiplier: (a * b) mod n by shift-and-add, one bit of
// b per cycle, LSB first, with every partial sum kept below n.
// ----------------------------------------------------------------------------
module mrsb_mulmod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrsb_pkg::mm_req_t             req,
    input  logic [mrsb_pkg::WIDTH-1:0]    modulus,
    output mrsb_pkg::mm_rsp_t             rsp
);
    import mrsb_pkg::*;

    // (x + y) mod n for x, y < n, without overflow
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] n
    );
        logic [WIDTH-1:0] room;
        begin
            room = n - y;
            if (x >= room) begin
                add_mod = x - room;
            end else begin
                add_mod = x + y;
            end
        end
    endfunction

    logic             busy_reg, busy_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] c_reg, c_next;
    logic [WIDTH-1:0] acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        a_next    = a_reg;
        c_next    = c_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            a_next    = req.op_a;
            c_next    = req.op_b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (c_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (c_reg[0]) begin
                    acc_next = add_mod(acc_reg, a_reg, modulus);
                end
                a_next = add_mod(a_reg, a_reg, modulus);
                c_next = c_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg   <= a_next;
        c_reg   <= c_next;
        acc_reg <= acc_next;
    end

    // finished once the multiplier bits run out
    assign rsp.done    = busy_reg && (c_reg == '0);
    assign rsp.product = acc_reg;

endmodule

// ===== design/miller_rabin_single_base_core.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_single_base_core
// Single-witness Miller-Rabin primality test on a bit-serial multiplier.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries candidate n in s_tdata[31:0] and witness b in
//   s_tdata[63:32]; one item is taken whenever s_tvalid and s_tready are high.
//   m_ channel returns one verdict per item in m_tdata[1:0]: 0 composite,
//   1 probably prime, 2 invalid base.
//   items are worked one at a time. an invalid base, a small n or an even n
//   is answered from the classify state without running the multiplier.
//   otherwise n-1 is split into m*2^k, b^m mod n is taken by square-and-multiply
//   and the result is squared up to k-1 more times. every modular product
//   runs through one shared shift-and-add multiplier at one multiplier bit
//   per cycle. the finished verdict sits in an output register; s_tready
//   returns high as soon as that register has taken it, so the next item can
//   start while the receiver stalls. a second verdict waits until the first
//   is taken. reset (aresetn low, synchronous) drops any item in flight and
//   clears m_tvalid.
// ----------------------------------------------------------------------------
module miller_rabin_single_base_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // candidate [31:0], witness [63:32]
    input  logic [mrsb_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // verdict [1:0], zero [7:2]
    output logic [mrsb_pkg::M_TDATA_W-1:0]     m_tdata
);
    import mrsb_pkg::*;

    mrsb_state_t state_reg, state_next;

    logic [WIDTH-1:0]     n_reg, n_next;
    logic [WIDTH-1:0]     b_reg, b_next;
    logic [WIDTH-1:0]     e_reg, e_next;
    logic [WIDTH-1:0]     acc_reg, acc_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [VERDICT_W-1:0] m_verdict_reg, m_verdict_next;

    logic [WIDTH-1:0] n_minus_1;
    logic             trivial;
    logic             out_free;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    mrsb_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .modulus (n_reg),
        .rsp     (mm_rsp)
    );

    assign n_minus_1 = n_reg - WIDTH'(1);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign trivial   = (b_reg <= WIDTH'(1)) || (b_reg >= n_reg) ||
                       (n_reg == SMALL_COMPOSITE) || (n_reg == SMALL_PRIME) ||
                       !n_reg[0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                state_next = trivial ? ST_DONE : ST_SPLIT;
            end
            ST_SPLIT: begin
                if (e_reg[0]) state_next = ST_POW;
            end
            ST_POW: begin
                if (e_reg == '0) begin
                    state_next = ST_TEST;
                end else if (e_reg[0]) begin
                    state_next = ST_POW_MUL;
                end else begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL: begin
                if (mm_rsp.done) state_next = ST_POW_SQR;
            end
            ST_POW_SQR: begin
                if (mm_rsp.done) state_next = ST_POW;
            end
            ST_TEST: begin
                if (acc_reg == WIDTH'(1) || acc_reg == n_minus_1) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                state_next = (k_reg <= K_W'(1)) ? ST_DONE : ST_LOOP_SQR;
            end
            ST_LOOP_SQR: begin
                if (mm_rsp.done) begin
                    state_next = (mm_rsp.product == n_minus_1) ? ST_DONE : ST_LOOP;
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_next         = n_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        verdict_next   = verdict_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_verdict_next = m_verdict_reg;
        s_tready       = 1'b0;
        mm_req.start   = 1'b0;
        mm_req.op_a    = acc_reg;
        mm_req.op_b    = b_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                n_next   = WIDTH'(s_tdata[FIELD_W-1:0]);
                b_next   = WIDTH'(s_tdata[2*FIELD_W-1:FIELD_W]);
            end
            ST_CLASSIFY: begin
                e_next   = n_minus_1;
                k_next   = '0;
                acc_next = WIDTH'(1);
                if (b_reg <= WIDTH'(1) || b_reg >= n_reg) begin
                    verdict_next = VERDICT_INVALID;
                end else if (n_reg == SMALL_PRIME) begin
                    verdict_next = VERDICT_PRIME;
                end else begin
                    verdict_next = VERDICT_COMPOSITE;
                end
            end
            ST_SPLIT: begin
                if (!e_reg[0]) begin
                    e_next = e_reg >> 1;
                    k_next = k_reg + K_W'(1);
                end
            end
            ST_POW: begin
                if (e_reg != '0) begin
                    mm_req.start = 1'b1;
                    if (!e_reg[0]) begin
                        mm_req.op_a = b_reg;
                    end
                end
            end
            ST_POW_MUL: begin
                // hand the squaring to the multiplier as the product lands
                if (mm_rsp.done) begin
                    acc_next     = mm_rsp.product;
                    mm_req.start = 1'b1;
                    mm_req.op_a  = b_reg;
                end
            end
            ST_POW_SQR: begin
                if (mm_rsp.done) begin
                    b_next = mm_rsp.product;
                    e_next = e_reg >> 1;
                end
            end
            ST_TEST: begin
                if (acc_reg == WIDTH'(1) || acc_reg == n_minus_1) begin
                    verdict_next = VERDICT_PRIME;
                end
            end
            ST_LOOP: begin
                if (k_reg > K_W'(1)) begin
                    mm_req.start = 1'b1;
                    mm_req.op_b  = acc_reg;
                end
            end
            ST_LOOP_SQR: begin
                if (mm_rsp.done) begin
                    acc_next = mm_rsp.product;
                    k_next   = k_reg - K_W'(1);
                    if (mm_rsp.product == n_minus_1) begin
                        verdict_next = VERDICT_PRIME;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_verdict_next = verdict_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        n_reg         <= n_next;
        b_reg         <= b_next;
        e_reg         <= e_next;
        acc_reg       <= acc_next;
        k_reg         <= k_next;
        verdict_reg   <= verdict_next;
        m_verdict_reg <= m_verdict_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_verdict_reg);

endmodule

// ===== design/mrsb_checker.sv =====
// ----------------------------------------------------------------------------
// mrsb_checker
// Port-level checks of the Miller-Rabin core, bound to the top level.
// ----------------------------------------------------------------------------
module mrsb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [mrsb_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [mrsb_pkg::M_TDATA_W-1:0]     m_tdata
);
    import mrsb_pkg::*;

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed");

    // only defined verdict codes with zero padding
    a_out_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:VERDICT_W] == '0) &&
                     (m_tdata[VERDICT_W-1:0] != 2'b11))
        else $error("bad verdict code");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

    // an invalid witness is answered without running the multiplier
    a_fast_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid &&
        (s_tdata[2*FIELD_W-1:FIELD_W] <= FIELD_W'(1))
        |-> ##3 m_tvalid)
        else $error("invalid witness not answered in time");

endmodule

bind miller_rabin_single_base_core mrsb_checker u_mrsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
